[rtl/core/windowed_heterozygosity_diversity_core_defines.svh]
// Assertion helpers used by the checker file.
`ifndef WINDOWED_HETEROZYGOSITY_DIVERSITY_CORE_DEFINES_SVH
`define WINDOWED_HETEROZYGOSITY_DIVERSITY_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define WHD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/whd_pkg.sv]
package whd_pkg;

  localparam int unsigned MAX_INDIVIDUALS_DEF = 64;
  localparam int unsigned COUNT_WIDTH_DEF     = 24;
  localparam int unsigned FRACTION_BITS_DEF   = 24;

  localparam int unsigned WINDOW_W   = 24;
  localparam int unsigned INDCNT_W   = 7;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned IND_W      = 6;
  localparam int unsigned ALLELE_W   = 3;
  localparam int unsigned TALLY_W    = 8;
  localparam int unsigned CALLED_W   = 7;
  localparam int unsigned PAIRS_W    = 19;
  localparam int unsigned SUM_OUT_W  = 48;
  localparam int unsigned CNT_OUT_W  = 24;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned HARM_DEPTH = 128;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INDIVIDUAL_COUNT = 1'b1;

  localparam logic [ALLELE_W-1:0] ALLELE_A = 3'd0;
  localparam logic [ALLELE_W-1:0] ALLELE_T = 3'd1;
  localparam logic [ALLELE_W-1:0] ALLELE_G = 3'd2;
  localparam logic [ALLELE_W-1:0] ALLELE_C = 3'd3;
  localparam logic [ALLELE_W-1:0] ALLELE_N = 3'd4;

  typedef struct packed {
    logic take;
    logic cnt_write;
    logic site_clear;
    logic pair_clear;
    logic pair_step;
    logic div_theta;
    logic div_pi;
    logic acc_theta;
    logic acc_pi;
    logic site_count;
    logic rep_read;
    logic rep_load;
    logic rep_next;
    logic rep_finish;
  } whd_cmd_t;

  typedef struct packed {
    logic act;
    logic los;
    logic poly;
    logic pair_last;
    logic div_done;
    logic boundary;
    logic rep_last;
    logic out_taken;
  } whd_sts_t;

  // H(2c-1) in fixed point: sum of rounded reciprocals 1..2c-1.
  function automatic logic [63:0] harm_sum(input int unsigned frac_bits,
                                           input int unsigned called);
    logic [63:0] acc;
    logic [63:0] one;
    int unsigned i;
    acc = 64'd0;
    one = 64'd1 << frac_bits;
    for (i = 1; i + 1 <= 2 * called; i++) begin
      acc = acc + (one + 64'(i / 2)) / 64'(i);
    end
    return acc;
  endfunction

endpackage

[rtl/core/whd_div.sv]
module whd_div #(
  parameter int unsigned NUM_W = 49,
  parameter int unsigned DEN_W = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, rnd_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W:0]   rem_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_twice;

  assign rem_sh    = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
  assign ge        = rem_sh >= {1'b0, den_r};
  assign rem_twice = {rem_r[DEN_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && !busy_r && rnd_r;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        rem_r  <= '0;
        q_r    <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
        q_r   <= {q_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          rnd_r  <= 1'b1;
        end
      end else if (rnd_r) begin
        // round half up on the final remainder
        if (rem_twice >= {1'b0, den_r}) begin
          q_r <= q_r + NUM_W'(1);
        end
        rnd_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[rtl/core/whd_ctrl.sv]
module whd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  whd_pkg::whd_sts_t  sts,
  output whd_pkg::whd_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_GENO, ST_SITE_CHK, ST_PAIRS, ST_THETA_GO, ST_THETA_WAIT,
    ST_PI_GO, ST_PI_WAIT, ST_COUNT, ST_REP_RD, ST_REP_LD, ST_REP_WAIT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_GENO;
        end
      end
      ST_GENO: begin
        if (!sts.act) begin
          state_nxt = ST_COUNT;
        end else begin
          cmd.cnt_write = 1'b1;
          state_nxt     = sts.los ? ST_SITE_CHK : ST_IDLE;
        end
      end
      ST_SITE_CHK: begin
        if (sts.poly) begin
          cmd.pair_clear = 1'b1;
          state_nxt      = ST_PAIRS;
        end else begin
          cmd.site_clear = 1'b1;
          state_nxt      = ST_COUNT;
        end
      end
      ST_PAIRS: begin
        cmd.pair_step = 1'b1;
        if (sts.pair_last) begin
          state_nxt = ST_THETA_GO;
        end
      end
      ST_THETA_GO: begin
        cmd.div_theta = 1'b1;
        state_nxt     = ST_THETA_WAIT;
      end
      ST_THETA_WAIT: begin
        if (sts.div_done) begin
          cmd.acc_theta = 1'b1;
          state_nxt     = ST_PI_GO;
        end
      end
      ST_PI_GO: begin
        cmd.div_pi = 1'b1;
        state_nxt  = ST_PI_WAIT;
      end
      ST_PI_WAIT: begin
        if (sts.div_done) begin
          cmd.acc_pi     = 1'b1;
          cmd.site_clear = 1'b1;
          state_nxt      = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd.site_count = 1'b1;
        state_nxt      = sts.boundary ? ST_REP_RD : ST_IDLE;
      end
      ST_REP_RD: begin
        cmd.rep_read = 1'b1;
        state_nxt    = ST_REP_LD;
      end
      ST_REP_LD: begin
        cmd.rep_load = 1'b1;
        state_nxt    = ST_REP_WAIT;
      end
      ST_REP_WAIT: begin
        if (sts.out_taken) begin
          if (sts.rep_last) begin
            cmd.rep_finish = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            cmd.rep_next = 1'b1;
            state_nxt    = ST_REP_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/whd_dpath.sv]
module whd_dpath #(
  parameter int unsigned MAX_INDIVIDUALS = whd_pkg::MAX_INDIVIDUALS_DEF,
  parameter int unsigned COUNT_WIDTH     = whd_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS   = whd_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [whd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [whd_pkg::WINDOW_W-1:0]        cfg_wdata,
  input  logic                                in_action,
  input  logic [whd_pkg::POS_W-1:0]           in_position,
  input  logic [whd_pkg::IND_W-1:0]           in_individual,
  input  logic [whd_pkg::ALLELE_W-1:0]        in_allele_first,
  input  logic [whd_pkg::ALLELE_W-1:0]        in_allele_second,
  input  logic                                in_last_of_site,
  input  logic                                in_last_of_contig,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [whd_pkg::POS_W-1:0]           out_report_position,
  output logic [whd_pkg::CNT_OUT_W-1:0]       out_sites_in_window,
  output logic [whd_pkg::CNT_OUT_W-1:0]       out_missing_in_window,
  output logic [whd_pkg::SUM_OUT_W-1:0]       out_theta_sum,
  output logic [whd_pkg::SUM_OUT_W-1:0]       out_pi_sum,
  output logic [whd_pkg::IND_W-1:0]           out_report_individual,
  output logic [whd_pkg::CNT_OUT_W-1:0]       out_het_count,
  output logic [whd_pkg::CNT_OUT_W-1:0]       out_hom_count,
  output logic [whd_pkg::CNT_OUT_W-1:0]       out_nocall_count,
  output logic                                out_last_of_report,
  input  whd_pkg::whd_cmd_t                   cmd,
  output whd_pkg::whd_sts_t                   sts
);

  localparam int unsigned IDX_W = (MAX_INDIVIDUALS > 1) ? $clog2(MAX_INDIVIDUALS) : 1;
  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned AW    = COUNT_WIDTH + FRACTION_BITS;
  localparam int unsigned HW    = FRACTION_BITS + 3;
  localparam int unsigned DEN_W = (HW > 16) ? HW : 16;
  localparam int unsigned NUM_W = (2 * FRACTION_BITS + 1 > FRACTION_BITS + 20) ?
                                  2 * FRACTION_BITS + 1 : FRACTION_BITS + 20;
  localparam int unsigned SW    = ((NUM_W > AW) ? NUM_W : AW) + 1;
  localparam int unsigned TW    = whd_pkg::TALLY_W;
  localparam int unsigned KW    = whd_pkg::CALLED_W;
  localparam int unsigned PW    = whd_pkg::PAIRS_W;
  localparam int unsigned IW    = whd_pkg::INDCNT_W;

  // configuration
  logic [whd_pkg::WINDOW_W-1:0] ws_r;
  logic [IW-1:0]                indcnt_r;
  logic [IW-1:0]                n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r     <= whd_pkg::WINDOW_W'(1000);
      indcnt_r <= IW'(1);
    end else if (cfg_we) begin
      if (cfg_index == whd_pkg::REG_WINDOW_SIZE) begin
        ws_r <= cfg_wdata;
      end else begin
        indcnt_r <= cfg_wdata[IW-1:0];
      end
    end
  end

  always_comb begin
    if (indcnt_r == '0) begin
      n_eff = IW'(1);
    end else if (indcnt_r > IW'(MAX_INDIVIDUALS)) begin
      n_eff = IW'(MAX_INDIVIDUALS);
    end else begin
      n_eff = indcnt_r;
    end
  end

  // captured transaction
  logic                         act_r, los_r, loc_r, ind_ok_r;
  logic [whd_pkg::POS_W-1:0]    pos_r;
  logic [IDX_W-1:0]             ind_r;
  logic [whd_pkg::ALLELE_W-1:0] a1_r, a2_r;
  logic [whd_pkg::ALLELE_W-1:0] a1_c, a2_c;
  logic                         ind_ok;

  assign a1_c   = (in_allele_first  > whd_pkg::ALLELE_N) ? whd_pkg::ALLELE_N : in_allele_first;
  assign a2_c   = (in_allele_second > whd_pkg::ALLELE_N) ? whd_pkg::ALLELE_N : in_allele_second;
  assign ind_ok = {1'b0, in_individual} < n_eff;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act_r    <= in_action;
      los_r    <= in_last_of_site;
      loc_r    <= in_last_of_contig;
      pos_r    <= in_position;
      ind_r    <= in_individual[IDX_W-1:0];
      ind_ok_r <= ind_ok;
      a1_r     <= a1_c;
      a2_r     <= a2_c;
    end
  end

  // per-individual counter memory: {het, hom, nocall}, valid bit per entry
  logic [3*CW-1:0]          cnt_mem [MAX_INDIVIDUALS];
  logic [MAX_INDIVIDUALS-1:0] valid_r;
  logic [3*CW-1:0]          rd_data_r;
  logic                     rd_valid_r;
  logic [IDX_W-1:0]         rd_addr;
  logic                     rd_en;
  logic [IDX_W-1:0]         rep_idx_r;
  logic [3*CW-1:0]          cur;
  logic [CW-1:0]            het_c, hom_c, noc_c;
  logic [3*CW-1:0]          wr_data;
  logic                     wr_en;

  assign rd_en   = cmd.take | cmd.rep_read;
  assign rd_addr = cmd.take ? in_individual[IDX_W-1:0] : rep_idx_r;
  assign cur     = rd_valid_r ? rd_data_r : '0;
  assign het_c   = cur[3*CW-1:2*CW];
  assign hom_c   = cur[2*CW-1:CW];
  assign noc_c   = cur[CW-1:0];
  assign wr_en   = cmd.cnt_write & ind_ok_r;

  always_comb begin
    wr_data = cur;
    if (a1_r != a2_r) begin
      if (het_c != '1) wr_data[3*CW-1:2*CW] = het_c + CW'(1);
    end else if (a1_r == whd_pkg::ALLELE_N) begin
      if (noc_c != '1) wr_data[CW-1:0] = noc_c + CW'(1);
    end else begin
      if (hom_c != '1) wr_data[2*CW-1:CW] = hom_c + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= cnt_mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
    if (wr_en) begin
      cnt_mem[ind_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (wr_en) valid_r[ind_r] <= 1'b1;
      if (cmd.rep_load) valid_r[rep_idx_r] <= 1'b0;
    end
  end

  // site state: allele tallies and called count
  logic [TW-1:0] tally_r [4];
  logic [KW-1:0] called_r;
  logic [2:0]    distinct;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < 4; b++) tally_r[b] <= '0;
      called_r <= '0;
    end else if (cmd.site_clear || (cmd.take && !in_action)) begin
      for (int b = 0; b < 4; b++) tally_r[b] <= '0;
      called_r <= '0;
    end else if (cmd.take && ind_ok) begin
      if (!(a1_c == whd_pkg::ALLELE_N && a2_c == whd_pkg::ALLELE_N) && called_r != '1) begin
        called_r <= called_r + KW'(1);
      end
      for (int b = 0; b < 4; b++) begin
        logic [TW:0] sum;
        sum = {1'b0, tally_r[b]} + (TW+1)'(a1_c == 3'(b)) + (TW+1)'(a2_c == 3'(b));
        tally_r[b] <= sum[TW] ? '1 : sum[TW-1:0];
      end
    end
  end

  always_comb begin
    distinct = '0;
    for (int b = 0; b < 4; b++) begin
      distinct = distinct + 3'(tally_r[b] != '0);
    end
  end

  // pairwise products, one per cycle
  logic [2:0]    pair_idx_r;
  logic [PW-1:0] pairs_r;
  logic [15:0]   den_r;
  logic [TW-1:0] op_a, op_b;
  logic [7:0]    m;

  assign m = {called_r, 1'b0};

  always_comb begin
    unique case (pair_idx_r)
      3'd0:    begin op_a = tally_r[0]; op_b = tally_r[1]; end
      3'd1:    begin op_a = tally_r[0]; op_b = tally_r[2]; end
      3'd2:    begin op_a = tally_r[0]; op_b = tally_r[3]; end
      3'd3:    begin op_a = tally_r[1]; op_b = tally_r[2]; end
      3'd4:    begin op_a = tally_r[1]; op_b = tally_r[3]; end
      3'd5:    begin op_a = tally_r[2]; op_b = tally_r[3]; end
      default: begin op_a = '0;         op_b = '0;         end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pair_clear) begin
      pair_idx_r <= '0;
      pairs_r    <= '0;
      den_r      <= 16'(m) * 16'(m - 8'd1);
    end else if (cmd.pair_step) begin
      pair_idx_r <= pair_idx_r + 3'd1;
      pairs_r    <= pairs_r + PW'(op_a * op_b);
    end
  end

  // H(2c-1) per called count
  logic [HW-1:0] harm_tab [whd_pkg::HARM_DEPTH];
  for (genvar g = 0; g < whd_pkg::HARM_DEPTH; g++) begin : g_harm
    assign harm_tab[g] = HW'(whd_pkg::harm_sum(FRACTION_BITS, g));
  end

  // shared divider
  logic [NUM_W-1:0] div_num, div_q;
  logic [DEN_W-1:0] div_den;
  logic             div_done;

  assign div_num = cmd.div_pi ? (NUM_W'(pairs_r) << (FRACTION_BITS + 1))
                              : (NUM_W'(1) << (2 * FRACTION_BITS));
  assign div_den = cmd.div_pi ? DEN_W'(den_r) : DEN_W'(harm_tab[called_r]);

  whd_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_theta | cmd.div_pi),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  function automatic logic [AW-1:0] sat_acc(input logic [AW-1:0] acc,
                                            input logic [NUM_W-1:0] inc);
    logic [SW-1:0] s;
    s = SW'(acc) + SW'(inc);
    return (s > SW'({AW{1'b1}})) ? {AW{1'b1}} : s[AW-1:0];
  endfunction

  // window accumulators
  logic [AW-1:0]                theta_r, pi_r;
  logic [CW-1:0]                sites_r, missing_r;
  logic [whd_pkg::WINDOW_W-1:0] phase_r;
  logic                         ws_hit, boundary;

  assign ws_hit   = (ws_r != '0) &&
                    ({1'b0, phase_r} + (whd_pkg::WINDOW_W+1)'(1) >= {1'b0, ws_r});
  assign boundary = loc_r | ws_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_r   <= '0;
      pi_r      <= '0;
      sites_r   <= '0;
      missing_r <= '0;
      phase_r   <= '0;
    end else if (cmd.rep_finish) begin
      theta_r   <= '0;
      pi_r      <= '0;
      sites_r   <= '0;
      missing_r <= '0;
    end else begin
      if (cmd.acc_theta) theta_r <= sat_acc(theta_r, div_q);
      if (cmd.acc_pi)    pi_r    <= sat_acc(pi_r, div_q);
      if (cmd.site_count) begin
        if (sites_r != '1) sites_r <= sites_r + CW'(1);
        if (!act_r && missing_r != '1) missing_r <= missing_r + CW'(1);
        if (boundary) begin
          phase_r <= '0;
        end else if (ws_r != '0) begin
          phase_r <= phase_r + whd_pkg::WINDOW_W'(1);
        end
      end
    end
  end

  // report sequencing and output register
  logic rep_last;
  logic out_valid_r;

  assign rep_last = ({1'b0, rep_idx_r} + (IDX_W+1)'(1)) == (IDX_W+1)'(n_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.rep_finish) begin
        rep_idx_r <= '0;
      end else if (cmd.rep_next) begin
        rep_idx_r <= rep_idx_r + IDX_W'(1);
      end
      if (cmd.rep_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rep_load) begin
      out_report_position   <= pos_r;
      out_sites_in_window   <= whd_pkg::CNT_OUT_W'(sites_r);
      out_missing_in_window <= whd_pkg::CNT_OUT_W'(missing_r);
      out_theta_sum         <= whd_pkg::SUM_OUT_W'(theta_r);
      out_pi_sum            <= whd_pkg::SUM_OUT_W'(pi_r);
      out_report_individual <= whd_pkg::IND_W'(rep_idx_r);
      out_het_count         <= whd_pkg::CNT_OUT_W'(het_c);
      out_hom_count         <= whd_pkg::CNT_OUT_W'(hom_c);
      out_nocall_count      <= whd_pkg::CNT_OUT_W'(noc_c);
      out_last_of_report    <= rep_last;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts           = '0;
    sts.act       = act_r;
    sts.los       = los_r;
    sts.poly      = (distinct > 3'd1) && (called_r != '0);
    sts.pair_last = (pair_idx_r == 3'd5);
    sts.div_done  = div_done;
    sts.boundary  = boundary;
    sts.rep_last  = rep_last;
    sts.out_taken = out_valid_r & out_ready;
  end

endmodule

[rtl/core/windowed_heterozygosity_diversity_core.sv]
// Channel  Handshake              Payload
// in       in_valid / in_ready    action, position, individual, alleles, site/contig marks
// out      out_valid / out_ready  one window result per individual
// cfg      cfg_we                 cfg_index, cfg_wdata (window_size, individual_count)
//
// Genotype item without site end: take, then counter write. Position item: take, check, then site count.
// Site close with two or more bases: the pairwise products, then the shared
// 1-bit-per-cycle divider (NUM_W = 49 at 24 fraction bits), run once for theta, once for pi.
// Report: one result per individual, each taken before the next is read; no input taken meanwhile.
// Synchronous active-low reset; counter memory is cleared through per-entry valid bits.
module windowed_heterozygosity_diversity_core #(
  parameter int unsigned MAX_INDIVIDUALS = whd_pkg::MAX_INDIVIDUALS_DEF,
  parameter int unsigned COUNT_WIDTH     = whd_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS   = whd_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [whd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [whd_pkg::WINDOW_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [whd_pkg::POS_W-1:0]     in_position,
  input  logic [whd_pkg::IND_W-1:0]     in_individual,
  input  logic [whd_pkg::ALLELE_W-1:0]  in_allele_first,
  input  logic [whd_pkg::ALLELE_W-1:0]  in_allele_second,
  input  logic                          in_last_of_site,
  input  logic                          in_last_of_contig,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [whd_pkg::POS_W-1:0]     out_report_position,
  output logic [whd_pkg::CNT_OUT_W-1:0] out_sites_in_window,
  output logic [whd_pkg::CNT_OUT_W-1:0] out_missing_in_window,
  output logic [whd_pkg::SUM_OUT_W-1:0] out_theta_sum,
  output logic [whd_pkg::SUM_OUT_W-1:0] out_pi_sum,
  output logic [whd_pkg::IND_W-1:0]     out_report_individual,
  output logic [whd_pkg::CNT_OUT_W-1:0] out_het_count,
  output logic [whd_pkg::CNT_OUT_W-1:0] out_hom_count,
  output logic [whd_pkg::CNT_OUT_W-1:0] out_nocall_count,
  output logic                          out_last_of_report
);

  whd_pkg::whd_cmd_t cmd;
  whd_pkg::whd_sts_t sts;

  whd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  whd_dpath #(
    .MAX_INDIVIDUALS (MAX_INDIVIDUALS),
    .COUNT_WIDTH     (COUNT_WIDTH),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_action             (in_action),
    .in_position           (in_position),
    .in_individual         (in_individual),
    .in_allele_first       (in_allele_first),
    .in_allele_second      (in_allele_second),
    .in_last_of_site       (in_last_of_site),
    .in_last_of_contig     (in_last_of_contig),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_report_position   (out_report_position),
    .out_sites_in_window   (out_sites_in_window),
    .out_missing_in_window (out_missing_in_window),
    .out_theta_sum         (out_theta_sum),
    .out_pi_sum            (out_pi_sum),
    .out_report_individual (out_report_individual),
    .out_het_count         (out_het_count),
    .out_hom_count         (out_hom_count),
    .out_nocall_count      (out_nocall_count),
    .out_last_of_report    (out_last_of_report),
    .cmd                   (cmd),
    .sts                   (sts)
  );

endmodule

[rtl/core/whd_checker.sv]
`include "windowed_heterozygosity_diversity_core_defines.svh"

module whd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [whd_pkg::IND_W-1:0]     out_report_individual
);

  // a stalled result holds
  `WHD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_report_individual), "result dropped while stalled")

  // no input is taken while a result is offered
  `WHD_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "input open during report")

  // out_valid drops after every result transaction
  `WHD_ASSERT_NEXT(a_out_gap, out_valid && out_ready, !out_valid, "result offered back to back")

  // in_ready drops after every accepted input item
  `WHD_ASSERT_NEXT(a_in_gap, in_valid && in_ready, !in_ready, "input accepted back to back")

endmodule

bind windowed_heterozygosity_diversity_core whd_checker u_whd_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;
  localparam longint unsigned SUM_MAX = 64'hFFFF_FFFF_FFFF;
  localparam int unsigned SETTLE_CYCLES = 150;

  typedef struct packed {
    logic [whd_pkg::POS_W-1:0]     position;
    logic [whd_pkg::CNT_OUT_W-1:0] sites;
    logic [whd_pkg::CNT_OUT_W-1:0] missing;
    logic [whd_pkg::SUM_OUT_W-1:0] theta;
    logic [whd_pkg::SUM_OUT_W-1:0] pi;
    logic [whd_pkg::IND_W-1:0]     individual;
    logic [whd_pkg::CNT_OUT_W-1:0] het;
    logic [whd_pkg::CNT_OUT_W-1:0] hom;
    logic [whd_pkg::CNT_OUT_W-1:0] nocall;
    logic                          last;
  } window_result_t;

  class diversity_scoreboard;
    window_result_t window_results_q[$];
    logic [whd_pkg::CNT_OUT_W-1:0] het_cnt[64], hom_cnt[64], nocall_cnt[64];
    int unsigned base_tally[4];
    int unsigned called;
    longint unsigned theta_acc, pi_acc;
    logic [whd_pkg::CNT_OUT_W-1:0] site_cnt, missing_cnt;
    int unsigned phase;
    int unsigned window_len, ind_reg;
    int unsigned mismatches, reports_seen, windows_closed;

    function new();
      for (int i = 0; i < 64; i++) begin
        het_cnt[i] = '0; hom_cnt[i] = '0; nocall_cnt[i] = '0;
      end
      drop_site();
      theta_acc = 0; pi_acc = 0; site_cnt = '0; missing_cnt = '0; phase = 0;
      window_len = 1000; ind_reg = 1;
      mismatches = 0; reports_seen = 0; windows_closed = 0;
    endfunction

    function void drop_site();
      for (int b = 0; b < 4; b++) base_tally[b] = 0;
      called = 0;
    endfunction

    function int unsigned active_count();
      if (ind_reg == 0) return 1;
      if (ind_reg > 64) return 64;
      return ind_reg;
    endfunction

    function logic [whd_pkg::CNT_OUT_W-1:0] bump(logic [whd_pkg::CNT_OUT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function longint unsigned sum_add(longint unsigned acc, longint unsigned inc);
      if (inc > SUM_MAX - acc) return SUM_MAX;
      return acc + inc;
    endfunction

    // 1/H(m-1) in Q24, rounded half up
    function longint unsigned watterson_inc(longint unsigned m);
      longint unsigned harm, q, r;
      harm = 0;
      for (longint unsigned i = 1; i + 1 <= m; i++)
        harm += ((64'd1 << whd_pkg::FRACTION_BITS_DEF) + i / 2) / i;
      if (harm == 0) return 0;
      q = (64'd1 << (2 * whd_pkg::FRACTION_BITS_DEF)) / harm;
      r = (64'd1 << (2 * whd_pkg::FRACTION_BITS_DEF)) % harm;
      if (2 * r >= harm) q++;
      return q;
    endfunction

    function void finish_site();
      longint unsigned t[4], m, pairs, den;
      int unsigned distinct;
      distinct = 0;
      for (int b = 0; b < 4; b++) begin
        t[b] = base_tally[b];
        if (t[b] != 0) distinct++;
      end
      m = 2 * called;
      if (distinct > 1 && m >= 2) begin
        theta_acc = sum_add(theta_acc, watterson_inc(m));
        pairs = t[0]*t[1] + t[0]*t[2] + t[0]*t[3] + t[1]*t[2] + t[1]*t[3] + t[2]*t[3];
        den = m * (m - 1);
        pi_acc = sum_add(pi_acc,
                         ((pairs << (whd_pkg::FRACTION_BITS_DEF + 1)) + den / 2) / den);
      end
      drop_site();
    endfunction

    function void note_transaction(logic act, logic [31:0] pos, logic [5:0] ind,
                                   logic [2:0] a1, logic [2:0] a2, logic los, logic loc);
      int unsigned n;
      logic [2:0] x, y;
      bit boundary;
      window_result_t r;
      n = active_count();
      if (act) begin
        if (ind < n) begin
          x = (a1 > whd_pkg::ALLELE_N) ? whd_pkg::ALLELE_N : a1;
          y = (a2 > whd_pkg::ALLELE_N) ? whd_pkg::ALLELE_N : a2;
          if (x != y) begin
            het_cnt[ind] = bump(het_cnt[ind]);
            if (called < 127) called++;
          end else if (x == whd_pkg::ALLELE_N) begin
            nocall_cnt[ind] = bump(nocall_cnt[ind]);
          end else begin
            hom_cnt[ind] = bump(hom_cnt[ind]);
            if (called < 127) called++;
          end
          if (x < whd_pkg::ALLELE_N && base_tally[x] < 255) base_tally[x]++;
          if (y < whd_pkg::ALLELE_N && base_tally[y] < 255) base_tally[y]++;
        end
        if (!los) return;
        finish_site();
      end else begin
        drop_site();
        missing_cnt = bump(missing_cnt);
      end
      site_cnt = bump(site_cnt);
      boundary = loc;
      if (window_len != 0) begin
        if (phase + 1 >= window_len) boundary = 1;
        else phase++;
      end
      if (!boundary) return;
      windows_closed++;
      for (int i = 0; i < n; i++) begin
        r.position = pos; r.sites = site_cnt; r.missing = missing_cnt;
        r.theta = theta_acc[47:0]; r.pi = pi_acc[47:0]; r.individual = i[5:0];
        r.het = het_cnt[i]; r.hom = hom_cnt[i]; r.nocall = nocall_cnt[i];
        r.last = (i + 1 == n);
        window_results_q.insert(window_results_q.size(), r);
        het_cnt[i] = '0; hom_cnt[i] = '0; nocall_cnt[i] = '0;
      end
      theta_acc = 0; pi_acc = 0; site_cnt = '0; missing_cnt = '0; phase = 0;
    endfunction

    function void check_result(window_result_t got);
      window_result_t exp;
      reports_seen++;
      if (window_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      exp = window_results_q.pop_front();
      if (got.position !== exp.position || got.sites !== exp.sites ||
          got.missing !== exp.missing || got.theta !== exp.theta ||
          got.pi !== exp.pi || got.individual !== exp.individual ||
          got.het !== exp.het || got.hom !== exp.hom ||
          got.nocall !== exp.nocall || got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch\n  exp %p\n  got %p", exp, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [whd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [whd_pkg::WINDOW_W-1:0] cfg_wdata;
  logic in_valid, in_ready, in_action, in_last_of_site, in_last_of_contig;
  logic [whd_pkg::POS_W-1:0] in_position;
  logic [whd_pkg::IND_W-1:0] in_individual;
  logic [whd_pkg::ALLELE_W-1:0] in_allele_first, in_allele_second;
  logic out_valid, out_ready, out_last_of_report;
  logic [whd_pkg::POS_W-1:0] out_report_position;
  logic [whd_pkg::CNT_OUT_W-1:0] out_sites_in_window, out_missing_in_window;
  logic [whd_pkg::SUM_OUT_W-1:0] out_theta_sum, out_pi_sum;
  logic [whd_pkg::IND_W-1:0] out_report_individual;
  logic [whd_pkg::CNT_OUT_W-1:0] out_het_count, out_hom_count, out_nocall_count;

  windowed_heterozygosity_diversity_core i_dut (.*);

  diversity_scoreboard sb = new();
  bit calm = 0;
  int unsigned items_sent = 0;
  logic [31:0] cur_pos = 1;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stall bursts until the calm tail
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // handshake signals are stable at the falling edge; the transaction lands next rise
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_report_position, out_sites_in_window, out_missing_in_window,
                       out_theta_sum, out_pi_sum, out_report_individual, out_het_count,
                       out_hom_count, out_nocall_count, out_last_of_report});
  end

  task automatic send(logic act, logic [5:0] ind, logic [2:0] a1, logic [2:0] a2,
                      logic los, logic loc);
    int unsigned gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act; in_position <= cur_pos; in_individual <= ind;
    in_allele_first <= a1; in_allele_second <= a2;
    in_last_of_site <= los; in_last_of_contig <= loc;
    forever begin
      @(negedge clk);
      if (in_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    sb.note_transaction(act, cur_pos, ind, a1, a2, los, loc);
    items_sent++;
    if (!act || los) begin
      if (loc) cur_pos = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFF0 : 32'd1;
      else cur_pos = cur_pos + 1;
    end
  endtask

  function automatic logic [2:0] pick_allele();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 15) return 3'($urandom_range(0, 3));
    if (r < 18) return whd_pkg::ALLELE_N;
    return 3'($urandom_range(5, 7));
  endfunction

  // one genotyped position; noise swaps in random individuals or drops the site end
  task automatic site(bit noisy, logic loc);
    int unsigned n;
    logic [5:0] who;
    n = sb.active_count();
    for (int i = 0; i < n; i++) begin
      who = i[5:0];
      if (noisy && $urandom_range(0, 3) == 0) who = 6'($urandom_range(0, 63));
      if (noisy && i == n - 1 && $urandom_range(0, 2) == 0) begin
        send(1'b1, who, pick_allele(), pick_allele(), 1'b0, 1'b0);
        return;
      end
      send(1'b1, who, pick_allele(), pick_allele(), i == n - 1, (i == n - 1) && loc);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.window_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [whd_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val[whd_pkg::WINDOW_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == whd_pkg::REG_WINDOW_SIZE) sb.window_len = val & 24'hFFFFFF;
    else sb.ind_reg = val & 7'h7F;
    @(posedge clk);
  endtask

  task automatic random_phase(int unsigned wlen, int unsigned nind, int unsigned budget);
    int unsigned start;
    wait_drained();
    write_reg(whd_pkg::REG_WINDOW_SIZE, wlen);
    write_reg(whd_pkg::REG_INDIVIDUAL_COUNT, nind);
    start = items_sent;
    while (items_sent - start < budget) begin
      case ($urandom_range(0, 9))
        0:       send(1'b0, 6'($urandom), 3'($urandom), 3'($urandom), 1'($urandom), 1'b0);
        1:       site(1'b1, 1'b0);
        2:       site(1'b0, 1'b1);
        default: site(1'b0, 1'b0);
      endcase
    end
    // close the contig so that every phase reports
    send(1'b0, 6'd0, whd_pkg::ALLELE_A, whd_pkg::ALLELE_A, 1'b0, 1'b1);
  endtask

  initial begin
    rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 0; in_action = 0; in_position = '0; in_individual = '0;
    in_allele_first = '0; in_allele_second = '0; in_last_of_site = 0;
    in_last_of_contig = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(whd_pkg::REG_WINDOW_SIZE, 7);
    write_reg(whd_pkg::REG_INDIVIDUAL_COUNT, 4);
    // hom, het, no-call and mixed N/base genotypes at one site
    send(1'b1, 6'd0, whd_pkg::ALLELE_A, whd_pkg::ALLELE_A, 1'b0, 1'b0);
    send(1'b1, 6'd1, whd_pkg::ALLELE_A, whd_pkg::ALLELE_T, 1'b0, 1'b0);
    send(1'b1, 6'd2, whd_pkg::ALLELE_N, whd_pkg::ALLELE_N, 1'b0, 1'b0);
    send(1'b1, 6'd3, whd_pkg::ALLELE_N, whd_pkg::ALLELE_C, 1'b1, 1'b0);
    // codes above N, and an ignored individual carrying the site end
    send(1'b1, 6'd0, 3'd5, 3'd7, 1'b0, 1'b0);
    send(1'b1, 6'd1, whd_pkg::ALLELE_G, whd_pkg::ALLELE_C, 1'b0, 1'b0);
    send(1'b1, 6'd63, whd_pkg::ALLELE_T, whd_pkg::ALLELE_G, 1'b1, 1'b0);
    send(1'b0, 6'h3F, 3'd7, 3'd7, 1'b1, 1'b0);
    // site cut short by a position without genotypes
    send(1'b1, 6'd0, whd_pkg::ALLELE_T, whd_pkg::ALLELE_G, 1'b0, 1'b0);
    send(1'b1, 6'd1, whd_pkg::ALLELE_C, whd_pkg::ALLELE_A, 1'b0, 1'b0);
    send(1'b0, 6'd0, whd_pkg::ALLELE_A, whd_pkg::ALLELE_A, 1'b0, 1'b0);
    send(1'b1, 6'd0, whd_pkg::ALLELE_G, whd_pkg::ALLELE_G, 1'b0, 1'b0);
    send(1'b1, 6'd1, whd_pkg::ALLELE_C, whd_pkg::ALLELE_C, 1'b0, 1'b0);
    send(1'b1, 6'd2, whd_pkg::ALLELE_T, whd_pkg::ALLELE_T, 1'b0, 1'b0);
    send(1'b1, 6'd3, whd_pkg::ALLELE_A, whd_pkg::ALLELE_A, 1'b1, 1'b0);
    send(1'b0, 6'd0, whd_pkg::ALLELE_A, whd_pkg::ALLELE_A, 1'b0, 1'b1);
    send(1'b0, 6'd0, whd_pkg::ALLELE_A, whd_pkg::ALLELE_A, 1'b0, 1'b0);
    send(1'b1, 6'd0, whd_pkg::ALLELE_G, whd_pkg::ALLELE_T, 1'b0, 1'b0);
    send(1'b1, 6'd1, whd_pkg::ALLELE_C, whd_pkg::ALLELE_A, 1'b0, 1'b0);
    send(1'b1, 6'd2, whd_pkg::ALLELE_T, whd_pkg::ALLELE_C, 1'b0, 1'b0);
    send(1'b1, 6'd3, whd_pkg::ALLELE_G, whd_pkg::ALLELE_A, 1'b1, 1'b1);

    random_phase(5, 3, 20);
    random_phase(0, 2, 15);
    random_phase(1, 1, 10);
    random_phase(24'hFFFFFF, 0, 12);
    random_phase(3, 127, 40);
    random_phase(9, 5, 12);
    calm = 1;
    random_phase(4, 2, 15);
    in_valid <= 1'b0;

    while (sb.window_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d input transactions, %0d windows closed, %0d results checked",
             items_sent, sb.windows_closed, sb.reports_seen);
    $display("%0d mismatches, %0d results still outstanding",
             sb.mismatches, sb.window_results_q.size());
    if (sb.mismatches == 0 && sb.window_results_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule
